FILE: sv/frl_pkg.sv
// shared types and constants for the frame rms level meter
package frl_pkg;

  localparam logic [1:0] CFG_ENABLE    = 2'd0;
  localparam logic [1:0] CFG_THRESHOLD = 2'd1;
  localparam logic [1:0] CFG_FORMAT    = 2'd2;

  localparam logic [1:0] FMT_S16      = 2'd0;
  localparam logic [1:0] FMT_U8       = 2'd1;
  localparam logic [1:0] FMT_UNSUP    = 2'd2;
  localparam logic [1:0] FMT_UNSUP_HI = 2'd3;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  localparam int unsigned U8_OFFSET = 128;
  localparam int unsigned SUM_W     = 47;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_SQRT,
    BK_STAT,
    BK_AVG,
    BK_OUT
  } bk_state_e;

  // frame summary handed from front to back
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [16:0]      count;
    logic             zero_vol;
    logic [31:0]      bytes;
    logic             overflow;
  } frame_t;

  typedef struct packed {
    logic [15:0] frame_volume;
    logic [31:0] frame_count;
    logic [31:0] silent_count;
    logic [31:0] active_count;
    logic [15:0] loudest_volume;
    logic [15:0] average_volume;
    logic [31:0] byte_total;
    logic        frame_overflow;
  } result_t;

  typedef struct packed {
    logic        command;
    logic [15:0] sample_value;
    logic        last_sample;
  } item_t;

endpackage

FILE: sv/frl_if.sv
// valid/ready channel interface carrying a packed payload
interface frl_if #(
  parameter int unsigned W = 1
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/frl_front.sv
// front end: sample conversion, sum of squares, frame bookkeeping
module frl_front import frl_pkg::*; #(
  parameter int unsigned MAX_FRAME_SAMPLES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  item_t       in_item_i,
  input  logic        enable_i,
  input  logic [1:0]  format_i,
  input  logic        drained_i,
  output logic        clear_o,
  output logic        push_o,
  input  logic        full_i,
  output frame_t      frame_o
);

  localparam logic [16:0] MaxCnt = 17'(MAX_FRAME_SAMPLES);

  logic [SUM_W-1:0] sum_q, sum_d;
  logic [16:0]      cnt_q, cnt_d;
  logic             ovf_q, ovf_d;
  logic [31:0]      bytes_q, bytes_d;
  logic [15:0]      mag;
  logic signed [16:0] s;
  logic             acc;

  // a clear waits for the back end to run dry; a last item needs a queue slot
  assign in_ready_o = (in_item_i.command == CMD_CLEAR) ? drained_i :
                      !(in_item_i.last_sample && full_i);
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    case (format_i)
      FMT_S16: s = {in_item_i.sample_value[15], in_item_i.sample_value};
      FMT_U8:  s = $signed({9'd0, in_item_i.sample_value[7:0]}) - 17'(U8_OFFSET);
      default: s = '0;
    endcase
    mag = s[16] ? 16'(-s) : s[15:0];
  end

  always_comb begin
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    bytes_d = bytes_q;
    clear_o = 1'b0;
    push_o  = 1'b0;
    frame_o = '0;
    if (acc) begin
      if (in_item_i.command == CMD_CLEAR) begin
        clear_o = 1'b1;
        sum_d = '0; cnt_d = '0; ovf_d = 1'b0; bytes_d = '0;
      end else if (enable_i) begin
        bytes_d = bytes_q + ((format_i == FMT_S16) ? 32'd2 : 32'd1);
        if (cnt_q < MaxCnt) begin
          sum_d = sum_q + SUM_W'(32'(mag) * 32'(mag));
          cnt_d = cnt_q + 17'd1;
        end else begin
          ovf_d = 1'b1;
        end
        if (in_item_i.last_sample) begin
          push_o = 1'b1;
          frame_o.sum      = sum_d;
          frame_o.count    = cnt_d;
          frame_o.zero_vol = format_i[1] || (cnt_d == '0);
          frame_o.bytes    = bytes_d;
          frame_o.overflow = ovf_d;
          sum_d = '0; cnt_d = '0; ovf_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0; cnt_q <= '0; ovf_q <= 1'b0; bytes_q <= '0;
    end else begin
      sum_q <= sum_d; cnt_q <= cnt_d; ovf_q <= ovf_d; bytes_q <= bytes_d;
    end
  end

endmodule

FILE: sv/frl_queue.sv
// two-entry queue of frame summaries
module frl_queue import frl_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   flush_i,
  input  logic   push_i,
  input  frame_t data_i,
  output logic   full_o,
  output logic   valid_o,
  input  logic   pop_i,
  output frame_t data_o
);

  frame_t      mem_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  n_q;

  assign full_o  = n_q == 2'd2;
  assign valid_o = n_q != 2'd0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; n_q <= '0;
    end else if (flush_i) begin
      wp_q <= 1'b0; rp_q <= 1'b0; n_q <= '0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i) rp_q <= !rp_q;
      n_q <= n_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

FILE: sv/frl_back.sv
// back end: division, square root and statistics update
module frl_back import frl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        clear_i,
  input  logic [15:0] threshold_i,
  input  logic        q_valid_i,
  output logic        q_pop_o,
  input  frame_t      q_data_i,
  output logic        idle_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output result_t     out_data_o
);

  bk_state_e state_q, state_d;
  logic [5:0]       step_q, step_d;
  logic [SUM_W-1:0] quo_q, quo_d;
  logic [16:0]      rem_q, rem_d, dvs_q, dvs_d;
  logic [31:0]      rad_q, rad_d;
  logic [17:0]      srem_q, srem_d;
  logic [15:0]      root_q, root_d;
  logic [15:0]      vol_q, vol_d;
  logic [31:0]      frames_q, frames_d, sil_q, sil_d, act_q, act_d;
  logic [15:0]      peak_q, peak_d, avg_q, avg_d;
  logic [47:0]      anum_q, anum_d;
  logic [47:0]      aquo_q, aquo_d;
  logic [32:0]      arem_q, arem_d;
  logic [31:0]      bytes_q, bytes_d;
  logic             ovf_q, ovf_d;
  logic             ov_q, ov_d;
  result_t          out_q, out_d;
  logic [17:0]      rtrial;
  logic [17:0]      rsh;
  logic [16:0]      dsh;
  logic [33:0]      ash;

  assign idle_o = (state_q == BK_IDLE) && !q_valid_i;
  assign out_valid_o = ov_q;
  assign out_data_o = out_q;

  always_comb begin
    state_d = state_q; step_d = step_q; quo_d = quo_q; rem_d = rem_q; dvs_d = dvs_q;
    rad_d = rad_q; srem_d = srem_q; root_d = root_q; vol_d = vol_q;
    frames_d = frames_q; sil_d = sil_q; act_d = act_q; peak_d = peak_q; avg_d = avg_q;
    anum_d = anum_q; aquo_d = aquo_q; arem_d = arem_q;
    bytes_d = bytes_q; ovf_d = ovf_q; ov_d = ov_q; out_d = out_q;
    q_pop_o = 1'b0;
    dsh = '0; rsh = '0; rtrial = '0; ash = '0;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (state_q)
      BK_IDLE: if (q_valid_i) begin
        q_pop_o = 1'b1;
        quo_d = q_data_i.sum; dvs_d = q_data_i.count; rem_d = '0;
        bytes_d = q_data_i.bytes; ovf_d = q_data_i.overflow;
        vol_d = '0; step_d = '0;
        state_d = q_data_i.zero_vol ? BK_STAT : BK_DIV;
      end
      // restoring divide, one quotient bit a cycle
      BK_DIV: begin
        dsh = {rem_q[15:0], quo_q[SUM_W-1]};
        quo_d = {quo_q[SUM_W-2:0], 1'b0};
        if (rem_q[16] || dsh >= dvs_q) begin
          rem_d = dsh - dvs_q; quo_d[0] = 1'b1;
        end else rem_d = dsh;
        step_d = step_q + 6'd1;
        if (step_q == 6'(SUM_W - 1)) begin
          step_d = '0; srem_d = '0; root_d = '0;
          rad_d = quo_d[31:0];
          state_d = BK_SQRT;
        end
      end
      // digit-by-digit square root, one root bit a cycle
      BK_SQRT: begin
        rsh = {srem_q[15:0], rad_q[31:30]};
        rtrial = {root_q, 2'b01};
        rad_d = {rad_q[29:0], 2'b00};
        if (rsh >= rtrial) begin
          srem_d = rsh - rtrial; root_d = {root_q[14:0], 1'b1};
        end else begin
          srem_d = rsh; root_d = {root_q[14:0], 1'b0};
        end
        step_d = step_q + 6'd1;
        if (step_q == 6'd15) begin
          vol_d = root_d; state_d = BK_STAT;
        end
      end
      BK_STAT: begin
        if (frames_q != '1) frames_d = frames_q + 32'd1;
        if (vol_q < threshold_i) begin
          if (sil_q != '1) sil_d = sil_q + 32'd1;
        end else if (act_q != '1) act_d = act_q + 32'd1;
        if (vol_q > peak_q) peak_d = vol_q;
        anum_d = 48'(avg_q) * 48'(frames_d - 32'd1) + 48'(vol_q);
        aquo_d = anum_d; arem_d = '0; step_d = '0;
        state_d = BK_AVG;
      end
      // average divide by frame count, one bit a cycle
      BK_AVG: begin
        ash = {arem_q, aquo_q[47]};
        aquo_d = {aquo_q[46:0], 1'b0};
        if (ash >= {2'b0, frames_q}) begin
          arem_d = 33'(ash - {2'b0, frames_q}); aquo_d[0] = 1'b1;
        end else arem_d = ash[32:0];
        step_d = step_q + 6'd1;
        if (step_q == 6'd47) begin
          avg_d = aquo_d[15:0]; state_d = BK_OUT;
        end
      end
      // result register frees the back end for the next frame
      BK_OUT: if (!ov_q || out_ready_i) begin
        ov_d = 1'b1; state_d = BK_IDLE;
        out_d = '{vol_q, frames_q, sil_q, act_q, peak_q, avg_q, bytes_q, ovf_q};
      end
      default: state_d = BK_IDLE;
    endcase
    if (clear_i) begin
      frames_d = '0; sil_d = '0; act_d = '0; peak_d = '0; avg_d = '0;
      state_d = BK_IDLE; q_pop_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE; ov_q <= 1'b0; out_q <= '0;
      frames_q <= '0; sil_q <= '0; act_q <= '0; peak_q <= '0; avg_q <= '0;
    end else begin
      state_q <= state_d; ov_q <= ov_d; out_q <= out_d;
      frames_q <= frames_d; sil_q <= sil_d; act_q <= act_d; peak_q <= peak_d;
      avg_q <= avg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d; quo_q <= quo_d; rem_q <= rem_d; dvs_q <= dvs_d;
    rad_q <= rad_d; srem_q <= srem_d; root_q <= root_d; vol_q <= vol_d;
    anum_q <= anum_d; aquo_q <= aquo_d; arem_q <= arem_d;
    bytes_q <= bytes_d; ovf_q <= ovf_d;
  end

endmodule

FILE: sv/frame_rms_level_statistics.sv
// top level of the frame rms level meter
// Samples are taken one per cycle and summed into the frame in progress; a
// frame end is queued (two deep) for the back end, which runs a bit-serial
// 47-bit divide, a 16-step square root and a 48-step divide for the running
// average (only the average divide when the volume is forced to zero), and
// the result register may wait on the receiver. Samples keep flowing while
// the back end works; only a frame end stalls while both queue slots
// are taken. A clear item waits until the queue is empty and the back end is
// idle, then zeroes the statistics and the frame in progress. Configuration
// is written through its own valid/ready port and is always ready.
module frame_rms_level_statistics import frl_pkg::*; #(
  parameter int unsigned MAX_FRAME_SAMPLES = 4096
) (
  input  logic clk_i,
  input  logic rst_ni,
  frl_if.sink   in_ch,
  frl_if.source out_ch,
  frl_if.sink   cfg_ch
);

  logic        enable_q;
  logic [15:0] thresh_q;
  logic [1:0]  format_q;
  logic        clear, push, full, q_valid, pop, drained;
  frame_t      f_in, f_out;
  result_t     res;
  logic [1:0]  cfg_idx;
  logic [15:0] cfg_val;

  assign cfg_ch.ready = 1'b1;
  assign cfg_idx = cfg_ch.data[17:16];
  assign cfg_val = cfg_ch.data[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0; thresh_q <= '0; format_q <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_idx)
        CFG_ENABLE:    enable_q <= cfg_val[0];
        CFG_THRESHOLD: thresh_q <= cfg_val;
        CFG_FORMAT:    format_q <= cfg_val[1:0];
        default: ;
      endcase
    end
  end

  frl_front #(.MAX_FRAME_SAMPLES(MAX_FRAME_SAMPLES)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready), .in_item_i(item_t'(in_ch.data)),
    .enable_i(enable_q), .format_i(format_q), .drained_i(drained),
    .clear_o(clear), .push_o(push), .full_i(full), .frame_o(f_in)
  );

  frl_queue u_queue (
    .clk_i, .rst_ni, .flush_i(clear), .push_i(push), .data_i(f_in), .full_o(full),
    .valid_o(q_valid), .pop_i(pop), .data_o(f_out)
  );

  frl_back u_back (
    .clk_i, .rst_ni, .clear_i(clear), .threshold_i(thresh_q),
    .q_valid_i(q_valid), .q_pop_o(pop), .q_data_i(f_out), .idle_o(drained),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready), .out_data_o(res)
  );

  assign out_ch.data = res;

endmodule

FILE: bench/tb_frl_if_note.sv
// notes package: the channel interface comes from the rtl; this file holds the bench-side helpers
package tb_frl_pkg;
  import frl_pkg::*;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_W      = 2 + CFG_DATA_W;

  // square-root of a mean square, floor result
  function automatic logic [15:0] root_of(input longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 16; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= v) r = t;
    end
    return r[15:0];
  endfunction
endpackage

FILE: bench/tb_top.sv
// testbench for the frame rms level meter: directed frames, random frames, back-pressure
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import frl_pkg::*;
  import tb_frl_pkg::*;

  localparam int unsigned MAX_SAMPLES = 4096;
  localparam int unsigned SETTLE      = 200;
  localparam int unsigned IDLE_LIMIT  = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  frl_if #(.W($bits(item_t)))   in_ch ();
  frl_if #(.W($bits(result_t))) out_ch ();
  frl_if #(.W(CFG_W))           cfg_ch ();

  frame_rms_level_statistics #(.MAX_FRAME_SAMPLES(MAX_SAMPLES)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  always #6 clk_i = ~clk_i;

  // bench copy of the meter state
  logic            meter_on;
  logic [15:0]     level_threshold;
  logic [1:0]      fmt;
  longint unsigned sq_sum;
  int unsigned     frame_len;
  logic            frame_ovf;
  logic [31:0]     n_frames, n_silent, n_active, bytes_seen;
  logic [15:0]     vol_peak, vol_avg;

  result_t     frame_results[$];
  int unsigned n_errors = 0;
  int unsigned n_checked = 0;
  int unsigned n_sent = 0;
  int unsigned burst_left = 0;
  int unsigned hold_req = 0;
  int unsigned idle_cycles = 0;

  function automatic logic [31:0] sat_up(input logic [31:0] x);
    return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
  endfunction

  task automatic clear_meter();
    sq_sum = 0; frame_len = 0; frame_ovf = 1'b0;
    n_frames = '0; n_silent = '0; n_active = '0;
    vol_peak = '0; vol_avg = '0; bytes_seen = '0;
  endtask

  // work out the result of one accepted item
  task automatic meter_item(input item_t it);
    int signed       s;
    longint unsigned mag;
    logic [15:0]     vol;
    longint unsigned n;
    result_t         r;
    if (it.command == CMD_CLEAR) begin
      clear_meter();
      return;
    end
    if (!meter_on) return;
    if (fmt == FMT_S16) begin
      s = $signed(it.sample_value);
      bytes_seen = bytes_seen + 32'd2;
    end else if (fmt == FMT_U8) begin
      s = int'(it.sample_value[7:0]) - int'(U8_OFFSET);
      bytes_seen = bytes_seen + 32'd1;
    end else begin
      s = 0;
      bytes_seen = bytes_seen + 32'd1;
    end
    mag = (s < 0) ? -s : s;
    if (frame_len < MAX_SAMPLES) begin
      sq_sum += mag * mag;
      frame_len++;
    end else begin
      frame_ovf = 1'b1;
    end
    if (!it.last_sample) return;
    if (fmt != FMT_S16 && fmt != FMT_U8 || frame_len == 0) vol = '0;
    else vol = root_of(sq_sum / frame_len);
    n_frames = sat_up(n_frames);
    if (vol < level_threshold) n_silent = sat_up(n_silent);
    else n_active = sat_up(n_active);
    if (vol > vol_peak) vol_peak = vol;
    n = n_frames;
    vol_avg = 16'((longint'(vol_avg) * (n - 1) + vol) / n);
    r.frame_volume   = vol;
    r.frame_count    = n_frames;
    r.silent_count   = n_silent;
    r.active_count   = n_active;
    r.loudest_volume = vol_peak;
    r.average_volume = vol_avg;
    r.byte_total     = bytes_seen;
    r.frame_overflow = frame_ovf;
    frame_results.push_back(r);
    sq_sum = 0; frame_len = 0; frame_ovf = 1'b0;
  endtask

  task automatic report(input string what, input longint got, input longint want);
    n_errors++;
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, n_checked);
  endtask

  // result checker
  always @(posedge clk_i) begin
    result_t got, want;
    if (out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (frame_results.size() == 0) begin
        report("unexpected result", got.frame_volume, -1);
      end else begin
        want = frame_results.pop_front();
        if (got.frame_volume != want.frame_volume)
          report("frame_volume", got.frame_volume, want.frame_volume);
        if (got.frame_count != want.frame_count)
          report("frame_count", got.frame_count, want.frame_count);
        if (got.silent_count != want.silent_count)
          report("silent_count", got.silent_count, want.silent_count);
        if (got.active_count != want.active_count)
          report("active_count", got.active_count, want.active_count);
        if (got.loudest_volume != want.loudest_volume)
          report("loudest_volume", got.loudest_volume, want.loudest_volume);
        if (got.average_volume != want.average_volume)
          report("average_volume", got.average_volume, want.average_volume);
        if (got.byte_total != want.byte_total)
          report("byte_total", got.byte_total, want.byte_total);
        if (got.frame_overflow != want.frame_overflow)
          report("frame_overflow", got.frame_overflow, want.frame_overflow);
      end
      n_checked++;
    end
  end

  // receiver stall pattern, with a long hold-off on request
  always @(negedge clk_i) begin
    int unsigned hold_cnt;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      hold_cnt = 0;
    end else if (hold_req != 0 || hold_cnt != 0) begin
      if (hold_req != 0) begin
        hold_cnt = hold_req;
        hold_req = 0;
      end
      hold_cnt--;
      out_ch.ready <= 1'b0;
    end else if (n_sent % 300 < 60) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_item(input logic cmd, input logic [15:0] val, input logic last);
    item_t it;
    if (burst_left == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
    end
    it.command = cmd;
    it.sample_value = val;
    it.last_sample = last;
    in_ch.data = it;
    in_ch.valid = 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    meter_item(it);
    n_sent++;
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic stop_sending();
    in_ch.valid = 1'b0;
    burst_left = 0;
  endtask

  // let the back end run dry before a register write
  task automatic drain();
    stop_sending();
    wait (frame_results.size() == 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_ch.data = {idx, val};
    cfg_ch.valid = 1'b1;
    do @(posedge clk_i); while (!cfg_ch.ready);
    if (idx == CFG_ENABLE) meter_on = val[0];
    else if (idx == CFG_THRESHOLD) level_threshold = val;
    else if (idx == CFG_FORMAT) fmt = val[1:0];
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic setup(input logic en, input logic [15:0] thr, input logic [1:0] f);
    drain();
    write_reg(CFG_ENABLE, {15'd0, en});
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_FORMAT, {14'd0, f});
  endtask

  task automatic test_disabled();
    // meter off after reset: samples and frame ends are ignored
    send_item(CMD_SAMPLE, 16'h7FFF, 1'b0);
    send_item(CMD_SAMPLE, 16'h8000, 1'b1);
  endtask

  task automatic test_s16_extremes();
    setup(1'b1, 16'd0, FMT_S16);
    send_item(CMD_SAMPLE, 16'h8000, 1'b1);
    send_item(CMD_SAMPLE, 16'h7FFF, 1'b1);
    send_item(CMD_SAMPLE, 16'h0000, 1'b1);
    send_item(CMD_SAMPLE, 16'h8000, 1'b0);
    send_item(CMD_SAMPLE, 16'h7FFF, 1'b0);
    send_item(CMD_SAMPLE, 16'hFFFF, 1'b1);
    // clear in the middle of a frame, then a fresh frame
    send_item(CMD_SAMPLE, 16'h1234, 1'b0);
    send_item(CMD_CLEAR, 16'hFFFF, 1'b1);
    send_item(CMD_SAMPLE, 16'h0100, 1'b1);
  endtask

  task automatic test_u8_and_unsupported();
    setup(1'b1, 16'hFFFF, FMT_U8);
    send_item(CMD_SAMPLE, 16'hFF00, 1'b1);
    send_item(CMD_SAMPLE, 16'h00FF, 1'b1);
    send_item(CMD_SAMPLE, 16'hAB80, 1'b0);
    // format changes mid-frame: earlier samples keep their conversion
    setup(1'b1, 16'd1, FMT_S16);
    send_item(CMD_SAMPLE, 16'h4000, 1'b1);
    setup(1'b1, 16'd0, FMT_UNSUP);
    send_item(CMD_SAMPLE, 16'h7FFF, 1'b0);
    send_item(CMD_SAMPLE, 16'h8000, 1'b1);
    setup(1'b1, 16'd0, FMT_UNSUP_HI);
    send_item(CMD_SAMPLE, 16'h1111, 1'b1);
    setup(1'b0, 16'd0, FMT_S16);
    send_item(CMD_SAMPLE, 16'h7FFF, 1'b1);
    send_item(CMD_CLEAR, 16'h0000, 1'b0);
  endtask

  task automatic random_frames(input int unsigned n_items);
    int unsigned done;
    int unsigned len;
    int unsigned k;
    logic [15:0] v;
    done = 0;
    while (done < n_items) begin
      k = $urandom_range(0, 99);
      if (k < 3) begin
        send_item(CMD_CLEAR, 16'($urandom), 1'($urandom));
        done++;
      end else begin
        len = (k < 8) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          v = 16'($urandom);
          if ($urandom_range(0, 3) == 0) v = 16'($signed(v) >>> $urandom_range(4, 14));
          send_item(CMD_SAMPLE, v, i == len - 1);
          done++;
        end
      end
    end
  endtask

  task automatic test_random();
    setup(1'b1, 16'd0, FMT_S16);
    random_frames(250);
    setup(1'b1, 16'($urandom_range(0, 20000)), FMT_S16);
    random_frames(250);
    setup(1'b1, 16'($urandom_range(0, 90)), FMT_U8);
    random_frames(150);
    setup(1'b1, 16'hFFFF, FMT_S16);
    random_frames(100);
    setup(1'b1, 16'd0, FMT_UNSUP);
    random_frames(30);
  endtask

  task automatic test_backpressure();
    setup(1'b1, 16'd3000, FMT_S16);
    hold_req = 800;
    for (int i = 0; i < 60; i++)
      send_item(CMD_SAMPLE, 16'($urandom), ($urandom_range(0, 2) == 0));
    send_item(CMD_SAMPLE, 16'($urandom), 1'b1);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    meter_on = 1'b0;
    level_threshold = '0;
    fmt = FMT_S16;
    clear_meter();
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_disabled();
    test_s16_extremes();
    test_u8_and_unsupported();
    test_random();
    test_backpressure();
    drain();
    $display("sent %0d items and checked %0d frame results", n_sent, n_checked);
    $display("covered both sample formats, unsupported formats, clears, back-pressure");
    if (n_errors == 0 && frame_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", n_errors, frame_results.size());
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
